/* hw/rtl/drfl_pkg.sv */
// Shared types, sizes, codes and helpers of the dual resource FIFO lock.
// No dependencies; every other file of the block refers to it by scoped names.
package drfl_pkg;

   localparam int WAIT_DEPTH = 16;
   localparam int TASK_COUNT = 32;
   localparam int PTR_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
   localparam int TASK_W     = 5;
   localparam int AMT_W      = 8;
   localparam int MASK_W     = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAKE    = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SUSP_SYNC  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SUSP_ASYNC = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_A       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_B       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_A     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_B     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MASK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ASYNC_MASK  = 3'd5;

   localparam logic [AMT_W-1:0]  MAX_RESET        = 8'hFF;
   localparam logic [AMT_W-1:0]  START_RESET      = 8'h00;
   localparam logic [MASK_W-1:0] VALID_MASK_RESET = 32'hFFFF_FFFF;
   localparam logic [MASK_W-1:0] ASYNC_MASK_RESET = 32'h0000_0000;
   localparam logic [TASK_W-1:0] NO_TASK          = 5'd0;
   localparam logic [AMT_W-1:0]  NO_AMOUNT        = 8'd0;

   // one waiting task
   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [AMT_W-1:0]  amt_b;
      logic [AMT_W-1:0]  amt_a;
   } wait_entry_type;

   // operands of the shared compare/add unit
   typedef struct packed {
      logic [AMT_W-1:0] x_a;
      logic [AMT_W-1:0] x_b;
      logic [AMT_W-1:0] y_a;
      logic [AMT_W-1:0] y_b;
      logic [AMT_W-1:0] lim_a;
      logic [AMT_W-1:0] lim_b;
   } calc_arg_type;

   typedef struct packed {
      logic             fit;    // x <= y on both resources
      logic [AMT_W-1:0] sum_a;  // min(x + y, lim)
      logic [AMT_W-1:0] sum_b;
   } calc_res_type;

   function automatic logic task_ok(logic [TASK_W-1:0] id, logic [MASK_W-1:0] mask);
      return (({1'b0, id} < TASK_COUNT) && mask[id]);
   endfunction

endpackage

/* hw/rtl/drfl_calc.sv */
// Shared compare and saturating add unit, reused by the reserve, add and scan steps of the sequencer.
// Depends on drfl_pkg.
module drfl_calc (
   input  drfl_pkg::calc_arg_type arg,
   output drfl_pkg::calc_res_type res
);

   logic [drfl_pkg::AMT_W:0] sum_a;
   logic [drfl_pkg::AMT_W:0] sum_b;

   assign sum_a = {1'b0, arg.x_a} + {1'b0, arg.y_a};
   assign sum_b = {1'b0, arg.x_b} + {1'b0, arg.y_b};

   always_comb begin
      res.fit   = (arg.x_a <= arg.y_a) && (arg.x_b <= arg.y_b);
      res.sum_a = (sum_a > {1'b0, arg.lim_a}) ? arg.lim_a : sum_a[drfl_pkg::AMT_W-1:0];
      res.sum_b = (sum_b > {1'b0, arg.lim_b}) ? arg.lim_b : sum_b[drfl_pkg::AMT_W-1:0];
   end

endmodule

/* hw/rtl/drfl_ring.sv */
// Wait queue storage: one write port, one registered read port.
// Depends on drfl_pkg.
module drfl_ring (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [drfl_pkg::PTR_W-1:0]    wr_addr,
   input  drfl_pkg::wait_entry_type      wr_data,
   input  logic [drfl_pkg::PTR_W-1:0]    rd_addr,
   output drfl_pkg::wait_entry_type      rd_data
);

   drfl_pkg::wait_entry_type mem [drfl_pkg::WAIT_DEPTH];
   drfl_pkg::wait_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dual_resource_fifo_lock_unit.sv */
// Dual resource FIFO lock: sequencer, lock state and config registers.
// Depends on drfl_pkg, drfl_calc and drfl_ring.
// States to rsp_valid: a reserve S_RSV_MAX, S_RSV_FIT (skipped if rejected), S_DONE; a release
// without owner or an unused kind S_DONE; make available under an owner S_ADD, S_DONE; a queue
// scan S_ADD, then S_SCAN_RD and S_SCAN_CHK per waiter dropped, then S_SCAN_RD or S_SCAN_CHK, S_DONE.
// One item at a time: a beat is taken only in S_IDLE, which S_DONE enters once the output register is free.
// Reset (synchronous): no owner, counts 0, queue empty, registers to reset values.
module dual_resource_fifo_lock_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [drfl_pkg::KIND_W-1:0]       req_kind,
   input  logic [drfl_pkg::TASK_W-1:0]       req_task_id,
   input  logic [drfl_pkg::AMT_W-1:0]        req_amount_a,
   input  logic [drfl_pkg::AMT_W-1:0]        req_amount_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [drfl_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_resumed_valid,
   output logic [drfl_pkg::TASK_W-1:0]       rsp_resumed_task,
   output logic                              rsp_owner_valid,
   output logic [drfl_pkg::TASK_W-1:0]       rsp_owner_task,
   output logic [drfl_pkg::AMT_W-1:0]        rsp_avail_a,
   output logic [drfl_pkg::AMT_W-1:0]        rsp_avail_b,
   input  logic                              csr_wr_en,
   input  logic [drfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [drfl_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_RSV_MAX  = 3'd1;
   localparam logic [2:0] S_RSV_FIT  = 3'd2;
   localparam logic [2:0] S_ADD      = 3'd3;
   localparam logic [2:0] S_SCAN_RD  = 3'd4;
   localparam logic [2:0] S_SCAN_CHK = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   localparam int W = drfl_pkg::AMT_W;
   localparam int T = drfl_pkg::TASK_W;

   logic [2:0] state_ff, state_in;

   // configuration
   logic [W-1:0]                  max_a_ff, max_a_in, max_b_ff, max_b_in;
   logic [drfl_pkg::MASK_W-1:0]   valid_mask_ff, valid_mask_in;
   logic [drfl_pkg::MASK_W-1:0]   async_mask_ff, async_mask_in;

   // lock state
   logic                          owner_ff, owner_in;
   logic [T-1:0]                  owner_id_ff, owner_id_in;
   logic [W-1:0]                  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [drfl_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [drfl_pkg::CNT_W-1:0]    ring_cnt_ff, ring_cnt_in;

   // item in progress
   logic [T-1:0]                  task_ff, task_in;
   logic [W-1:0]                  amt_a_ff, amt_a_in, amt_b_ff, amt_b_in;
   logic [drfl_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          res_v_ff, res_v_in;
   logic [T-1:0]                  res_t_ff, res_t_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [drfl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_res_v_ff, rsp_res_v_in;
   logic [T-1:0]                  rsp_res_t_ff, rsp_res_t_in;
   logic                          rsp_own_v_ff, rsp_own_v_in;
   logic [T-1:0]                  rsp_own_t_ff, rsp_own_t_in;
   logic [W-1:0]                  rsp_avail_a_ff, rsp_avail_a_in;
   logic [W-1:0]                  rsp_avail_b_ff, rsp_avail_b_in;

   drfl_pkg::calc_arg_type        calc_arg;
   drfl_pkg::calc_res_type        calc_res;
   drfl_pkg::wait_entry_type      ring_wr_data, ring_rd_data;
   logic                          ring_wr_en;
   logic [drfl_pkg::PTR_W-1:0]    tail;
   logic [drfl_pkg::CNT_W:0]      tail_sum;
   logic [drfl_pkg::PTR_W-1:0]    head_next;
   logic                          req_beat;

   drfl_calc u_calc (
      .arg (calc_arg),
      .res (calc_res)
   );

   drfl_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (tail),
      .wr_data (ring_wr_data),
      .rd_addr (head_ff),
      .rd_data (ring_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;

   // wrap tail and head for any queue depth
   assign tail_sum  = {{(drfl_pkg::CNT_W + 1 - drfl_pkg::PTR_W){1'b0}}, head_ff}
                    + {1'b0, ring_cnt_ff};
   assign tail      = (tail_sum >= drfl_pkg::WAIT_DEPTH)
                    ? drfl_pkg::PTR_W'(tail_sum - drfl_pkg::WAIT_DEPTH)
                    : tail_sum[drfl_pkg::PTR_W-1:0];
   assign head_next = (head_ff == drfl_pkg::PTR_W'(drfl_pkg::WAIT_DEPTH - 1))
                    ? '0 : head_ff + 1'b1;

   assign ring_wr_data.task_id = task_ff;
   assign ring_wr_data.amt_a   = amt_a_ff;
   assign ring_wr_data.amt_b   = amt_b_ff;

   // operand select for the shared unit
   always_comb begin
      calc_arg.x_a   = amt_a_ff;
      calc_arg.x_b   = amt_b_ff;
      calc_arg.y_a   = max_a_ff;
      calc_arg.y_b   = max_b_ff;
      calc_arg.lim_a = max_a_ff;
      calc_arg.lim_b = max_b_ff;
      case (state_ff)
         S_RSV_FIT: begin
            calc_arg.y_a = count_a_ff;
            calc_arg.y_b = count_b_ff;
         end
         S_ADD: begin
            calc_arg.x_a = count_a_ff;
            calc_arg.x_b = count_b_ff;
            calc_arg.y_a = amt_a_ff;
            calc_arg.y_b = amt_b_ff;
         end
         S_SCAN_CHK: begin
            calc_arg.x_a = ring_rd_data.amt_a;
            calc_arg.x_b = ring_rd_data.amt_b;
            calc_arg.y_a = count_a_ff;
            calc_arg.y_b = count_b_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      max_a_in       = max_a_ff;
      max_b_in       = max_b_ff;
      valid_mask_in  = valid_mask_ff;
      async_mask_in  = async_mask_ff;
      owner_in       = owner_ff;
      owner_id_in    = owner_id_ff;
      count_a_in     = count_a_ff;
      count_b_in     = count_b_ff;
      head_in        = head_ff;
      ring_cnt_in    = ring_cnt_ff;
      task_in        = task_ff;
      amt_a_in       = amt_a_ff;
      amt_b_in       = amt_b_ff;
      status_in      = status_ff;
      res_v_in       = res_v_ff;
      res_t_in       = res_t_ff;
      ring_wr_en     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_res_v_in   = rsp_res_v_ff;
      rsp_res_t_in   = rsp_res_t_ff;
      rsp_own_v_in   = rsp_own_v_ff;
      rsp_own_t_in   = rsp_own_t_ff;
      rsp_avail_a_in = rsp_avail_a_ff;
      rsp_avail_b_in = rsp_avail_b_ff;

      if (csr_wr_en) begin
         case (csr_index)
            drfl_pkg::CSR_MAX_A:      max_a_in      = csr_wr_data[W-1:0];
            drfl_pkg::CSR_MAX_B:      max_b_in      = csr_wr_data[W-1:0];
            // start count writes are ignored; reset sets the counts to START_RESET (zero)
            drfl_pkg::CSR_START_A:    begin end
            drfl_pkg::CSR_START_B:    begin end
            drfl_pkg::CSR_VALID_MASK: valid_mask_in = csr_wr_data[drfl_pkg::MASK_W-1:0];
            drfl_pkg::CSR_ASYNC_MASK: async_mask_in = csr_wr_data[drfl_pkg::MASK_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               task_in   = req_task_id;
               amt_a_in  = req_amount_a;
               amt_b_in  = req_amount_b;
               status_in = drfl_pkg::ST_GRANTED;
               res_v_in  = 1'b0;
               res_t_in  = drfl_pkg::NO_TASK;
               case (req_kind)
                  drfl_pkg::KIND_RESERVE: state_in = S_RSV_MAX;
                  drfl_pkg::KIND_RELEASE: begin
                     if (owner_ff) begin
                        owner_in    = 1'b0;
                        owner_id_in = drfl_pkg::NO_TASK;
                        amt_a_in    = drfl_pkg::NO_AMOUNT;
                        amt_b_in    = drfl_pkg::NO_AMOUNT;
                        state_in    = S_ADD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  drfl_pkg::KIND_MAKE: state_in = S_ADD;
                  default: begin
                     status_in = drfl_pkg::ST_REJECTED;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_RSV_MAX: begin
            if (!calc_res.fit || !drfl_pkg::task_ok(task_ff, valid_mask_ff)) begin
               status_in = drfl_pkg::ST_REJECTED;
               state_in  = S_DONE;
            end else begin
               state_in = S_RSV_FIT;
            end
         end
         S_RSV_FIT: begin
            state_in = S_DONE;
            if (!owner_ff && calc_res.fit) begin
               owner_in    = 1'b1;
               owner_id_in = task_ff;
               status_in   = drfl_pkg::ST_GRANTED;
            end else if (ring_cnt_ff >= drfl_pkg::CNT_W'(drfl_pkg::WAIT_DEPTH)) begin
               status_in = drfl_pkg::ST_QUEUE_FULL;
            end else begin
               ring_wr_en  = 1'b1;
               ring_cnt_in = ring_cnt_ff + 1'b1;
               status_in   = async_mask_ff[task_ff] ? drfl_pkg::ST_SUSP_ASYNC
                                                    : drfl_pkg::ST_SUSP_SYNC;
            end
         end
         S_ADD: begin
            count_a_in = calc_res.sum_a;
            count_b_in = calc_res.sum_b;
            state_in   = owner_ff ? S_DONE : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            // head entry reads out on this edge
            state_in = (ring_cnt_ff == '0) ? S_DONE : S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (!calc_res.fit) begin
               state_in = S_DONE;
            end else begin
               head_in     = head_next;
               ring_cnt_in = ring_cnt_ff - 1'b1;
               if (drfl_pkg::task_ok(ring_rd_data.task_id, valid_mask_ff)) begin
                  owner_in    = 1'b1;
                  owner_id_in = ring_rd_data.task_id;
                  res_v_in    = 1'b1;
                  res_t_in    = ring_rd_data.task_id;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_res_v_in   = res_v_ff;
               rsp_res_t_in   = res_t_ff;
               rsp_own_v_in   = owner_ff;
               rsp_own_t_in   = owner_id_ff;
               rsp_avail_a_in = count_a_ff;
               rsp_avail_b_in = count_b_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_a_ff      <= drfl_pkg::MAX_RESET;
         max_b_ff      <= drfl_pkg::MAX_RESET;
         valid_mask_ff <= drfl_pkg::VALID_MASK_RESET;
         async_mask_ff <= drfl_pkg::ASYNC_MASK_RESET;
         owner_ff      <= 1'b0;
         owner_id_ff   <= drfl_pkg::NO_TASK;
         count_a_ff    <= drfl_pkg::START_RESET;
         count_b_ff    <= drfl_pkg::START_RESET;
         head_ff       <= '0;
         ring_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_a_ff      <= max_a_in;
         max_b_ff      <= max_b_in;
         valid_mask_ff <= valid_mask_in;
         async_mask_ff <= async_mask_in;
         owner_ff      <= owner_in;
         owner_id_ff   <= owner_id_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         head_ff       <= head_in;
         ring_cnt_ff   <= ring_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff        <= task_in;
      amt_a_ff       <= amt_a_in;
      amt_b_ff       <= amt_b_in;
      status_ff      <= status_in;
      res_v_ff       <= res_v_in;
      res_t_ff       <= res_t_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_res_v_ff   <= rsp_res_v_in;
      rsp_res_t_ff   <= rsp_res_t_in;
      rsp_own_v_ff   <= rsp_own_v_in;
      rsp_own_t_ff   <= rsp_own_t_in;
      rsp_avail_a_ff <= rsp_avail_a_in;
      rsp_avail_b_ff <= rsp_avail_b_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_resumed_valid = rsp_res_v_ff;
   assign rsp_resumed_task  = rsp_res_t_ff;
   assign rsp_owner_valid   = rsp_own_v_ff;
   assign rsp_owner_task    = rsp_own_t_ff;
   assign rsp_avail_a       = rsp_avail_a_ff;
   assign rsp_avail_b       = rsp_avail_b_ff;

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      ring_cnt_ff <= drfl_pkg::CNT_W'(drfl_pkg::WAIT_DEPTH))
      else $error("wait queue count above depth");

   a_scan_no_owner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD || state_ff == S_SCAN_CHK) |-> !owner_ff)
      else $error("queue scanned while the lock has an owner");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (ring_cnt_ff != '0))
      else $error("queue entry checked while queue is empty");

   a_resume_owner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_v_ff) |-> (rsp_own_v_ff && rsp_own_t_ff == rsp_res_t_ff))
      else $error("resumed task is not the owner");

endmodule
